FILE: sv/lsbx_pkg.sv
// Shared types, register indexes and helper functions for the LSB bit extractor.
// No dependencies; lsbx_unpack, lsbx_out_queue and the top level import this package.
package lsbx_pkg;

  localparam int unsigned CntW  = 4;  // width of a per-channel bit count register
  localparam int unsigned BurstN = 3; // most bytes one pixel can release

  typedef enum logic [1:0] {
    REG_RED_BITS   = 2'd0,
    REG_GREEN_BITS = 2'd1,
    REG_BLUE_BITS  = 2'd2
  } lsbx_reg_e;

  // Running extraction state carried from pixel to pixel.
  typedef struct packed {
    logic [7:0] bit_buffer;
    logic [2:0] bit_count;
    logic       message_done;
  } lsbx_state_t;

  // Bytes released by one pixel, oldest in entry 0.
  typedef struct packed {
    logic [BurstN-1:0][7:0] data;
    logic [BurstN-1:0]      eom;
    logic [1:0]             cnt;
  } lsbx_burst_t;

  // Counts above eight behave as eight.
  function automatic logic [CntW-1:0] clamp_count(logic [CntW-1:0] n);
    logic [CntW-1:0] r;
    r = (n > CntW'(8)) ? CntW'(8) : n;
    return r;
  endfunction

  // Mask of the n low bits of a channel, n in 0..8.
  function automatic logic [7:0] low_mask(logic [CntW-1:0] n);
    logic [8:0] m;
    m = (9'd1 << n) - 9'd1;
    return m[7:0];
  endfunction

endpackage

FILE: sv/lsbx_if.sv
// Valid/ready channel interfaces: pixels in, recovered bytes out.
// Depends on nothing.
interface lsbx_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface lsbx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       last_of_run;

  modport source (output valid, data_byte, end_of_message, last_of_run, input ready);
  modport sink   (input valid, data_byte, end_of_message, last_of_run, output ready);
endinterface

FILE: sv/lsbx_unpack.sv
// Combinational bit gathering for one pixel: splices channel bits onto the buffer,
// slices out whole bytes and finds the terminator. Depends on lsbx_pkg.
module lsbx_unpack
  import lsbx_pkg::*;
(
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  input  logic            frame_start_i,
  input  logic [CntW-1:0] red_bits_i,
  input  logic [CntW-1:0] green_bits_i,
  input  logic [CntW-1:0] blue_bits_i,
  input  lsbx_state_t     state_i,
  output lsbx_state_t     state_o,
  output lsbx_burst_t     burst_o
);

  lsbx_state_t     cur;
  logic [CntW-1:0] nr, ng, nb;
  logic [31:0]     acc_r, acc_g, acc_b;
  logic [4:0]      total;
  logic [1:0]      nbytes;
  logic [4:0]      sh   [BurstN];
  logic [7:0]      byt  [BurstN];
  logic [BurstN-1:0] zero;

  always_comb begin
    // A frame start clears the state before this pixel is taken in.
    cur = frame_start_i ? '0 : state_i;
    nr  = clamp_count(red_bits_i);
    ng  = clamp_count(green_bits_i);
    nb  = clamp_count(blue_bits_i);

    acc_r = ({24'd0, cur.bit_buffer} << nr) | {24'd0, red_i & low_mask(nr)};
    acc_g = (acc_r << ng) | {24'd0, green_i & low_mask(ng)};
    acc_b = (acc_g << nb) | {24'd0, blue_i & low_mask(nb)};
    total = 5'(cur.bit_count) + 5'(nr) + 5'(ng) + 5'(nb);
    nbytes = total[4:3];

    for (int k = 0; k < BurstN; k++) begin
      sh[k]   = total - 5'(8 * (k + 1));
      byt[k]  = 8'(acc_b >> sh[k]);
      zero[k] = (nbytes > 2'(k)) && (byt[k] == 8'd0);
    end

    burst_o.data = {byt[2], byt[1], byt[0]};
    burst_o.eom  = '0;
    burst_o.cnt  = nbytes;
    state_o.bit_buffer   = acc_b[7:0] & low_mask({1'b0, total[2:0]});
    state_o.bit_count    = total[2:0];
    state_o.message_done = 1'b0;

    // Stop at the first zero byte and drop the rest of the pixel.
    if (zero[0]) begin
      burst_o.cnt = 2'd1;
      burst_o.eom = 3'b001;
    end else if (zero[1]) begin
      burst_o.cnt = 2'd2;
      burst_o.eom = 3'b010;
    end else if (zero[2]) begin
      burst_o.cnt = 2'd3;
      burst_o.eom = 3'b100;
    end
    if (zero != '0) begin
      state_o = '{bit_buffer: 8'd0, bit_count: 3'd0, message_done: 1'b1};
    end

    // Message already ended: release nothing and hold the state.
    if (cur.message_done) begin
      burst_o.cnt = 2'd0;
      burst_o.eom = '0;
      state_o     = cur;
    end
  end

endmodule

FILE: sv/lsbx_out_queue.sv
// Result register for one pixel's burst of bytes, drained one byte per cycle while the sink is ready.
// Depends on lsbx_pkg and lsbx_byte_if.
module lsbx_out_queue
  import lsbx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  lsbx_burst_t burst_i,
  output logic        free_o,
  lsbx_byte_if.source out
);

  lsbx_burst_t burst_q;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  idx_q, idx_d;
  logic        last;
  logic        pop;

  always_comb begin
    out.valid          = idx_q < cnt_q;
    out.data_byte      = burst_q.data[idx_q];
    out.end_of_message = burst_q.eom[idx_q];
    last               = idx_q == (cnt_q - 2'd1);
    out.last_of_run    = last;
    pop                = out.valid && out.ready;
    free_o             = !out.valid || (out.ready && last);

    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = burst_i.cnt;
      idx_d = 2'd0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

FILE: sv/lsb_stego_bit_extractor_unit.sv
// Top level of the LSB steganography bit extractor.
// Depends on lsbx_pkg, lsbx_if, lsbx_unpack and lsbx_out_queue.
//
// Each pixel transaction hands in red, green and blue; the unit takes the configured
// number of low bits of each channel (red, then green, then blue, MSB first), packs
// them into bytes and releases every full byte on the byte channel, with last_of_run
// marking the final byte of a pixel. The first zero byte is flagged end_of_message;
// afterwards pixels release nothing until one arrives with frame_start set, which
// clears the bit buffer before that pixel is used. Counts of 9..15 act as 8, zero
// skips the channel. A pixel is held in the input register, decoded there in a single
// pass and loaded into the result register; its bytes then leave one per cycle while
// byt.ready is high. The next pixel advances into the result register as the last byte
// of the previous burst leaves, or at once if that burst released nothing.
// The user must write the configuration registers only while the unit is idle; the
// unit itself does not enforce this.
module lsb_stego_bit_extractor_unit
  import lsbx_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  lsbx_pix_if.sink        pix,
  lsbx_byte_if.source     byt,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CntW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [CntW-1:0] red_bits_q, green_bits_q, blue_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_bits_q   <= CntW'(1);
      green_bits_q <= CntW'(1);
      blue_bits_q  <= CntW'(1);
    end else if (cfg_we_i) begin
      unique case (lsbx_reg_e'(cfg_idx_i))
        REG_RED_BITS:   red_bits_q   <= cfg_data_i;
        REG_GREEN_BITS: green_bits_q <= cfg_data_i;
        REG_BLUE_BITS:  blue_bits_q  <= cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Input register.
  logic       in_vld_q;
  logic [7:0] red_q, green_q, blue_q;
  logic       fs_q;
  logic       q_free;
  logic       advance;

  // Advance the held pixel when the result register can take its burst.
  assign advance   = in_vld_q && q_free;
  assign pix.ready = !in_vld_q || q_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pix.ready) begin
      in_vld_q <= pix.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix.valid && pix.ready) begin
      red_q   <= pix.red;
      green_q <= pix.green;
      blue_q  <= pix.blue;
      fs_q    <= pix.frame_start;
    end
  end

  // Running bit state, updated as each pixel advances.
  lsbx_state_t state_q, state_d;
  lsbx_burst_t burst;

  lsbx_unpack u_unpack (
    .red_i         (red_q),
    .green_i       (green_q),
    .blue_i        (blue_q),
    .frame_start_i (fs_q),
    .red_bits_i    (red_bits_q),
    .green_bits_i  (green_bits_q),
    .blue_bits_i   (blue_bits_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .burst_o       (burst)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  lsbx_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .burst_i (burst),
    .free_o  (q_free),
    .out     (byt)
  );

`ifndef SYNTH
  // The terminator always closes its pixel's run.
  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byt.valid && byt.end_of_message |-> byt.last_of_run)
    else $error("end_of_message byte not marked last_of_run");

  // Once the message has ended the bit buffer stays empty.
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.message_done |-> (state_q.bit_count == 3'd0) && (state_q.bit_buffer == 8'd0))
    else $error("bit buffer not empty after terminator");

  // A pixel after the terminator without frame start releases no byte.
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.message_done && !fs_q |=> !byt.valid)
    else $error("byte released after end of message");
`endif

endmodule
